>>> hw/rtl/fw2hw_pkg.sv
// ----------------------------------------------------------------------------
// fw2hw_pkg
// Shared types and constants of the fullwidth to halfwidth converter.
// ----------------------------------------------------------------------------
package fw2hw_pkg;

   localparam logic [3:0]  LEAD_NIBBLE = 4'hE;
   localparam logic [15:0] FW_LOW      = 16'hFF01;
   localparam logic [15:0] FW_HIGH     = 16'hFF5E;
   localparam logic [15:0] FW_OFFSET   = 16'hFEE0;

   // most bytes one transaction can release
   localparam int MAX_BYTES   = 3;
   localparam int QUEUE_DEPTH = 6;

   typedef enum logic [2:0] {
      PEND_NONE = 3'b001,
      PEND_LEAD = 3'b010,
      PEND_TWO  = 3'b100
   } pend_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } item_type;

   // bytes released by one input byte, item[0] goes out first
   typedef struct packed {
      logic [1:0]                   cnt;
      item_type [MAX_BYTES-1:0]     item;
   } grp_type;

endpackage

>>> hw/rtl/fw2hw_decode.sv
// ----------------------------------------------------------------------------
// fw2hw_decode
// Input register, group buffering and fullwidth decode of one byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module fw2hw_decode
   import fw2hw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       room,
   output logic       fire,
   output grp_type    grp
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   pend_type   pend_ff, pend_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] second_ff, second_in;
   logic [15:0] cp;
   logic [15:0] half;
   logic        in_range;

   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign cp       = {lead_ff[3:0], second_ff[5:0], in_byte_ff[5:0]};
   assign in_range = (cp >= FW_LOW) && (cp <= FW_HIGH);
   assign half     = cp - FW_OFFSET;

   always_comb begin
      pend_in   = pend_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      grp       = '0;
      if (fire) begin
         unique case (pend_ff)
            PEND_LEAD: begin
               if (in_last_ff) begin
                  // text ends right after a lead: both go out as they are
                  grp.cnt          = 2'd2;
                  grp.item[0].data = lead_ff;
                  grp.item[1].data = in_byte_ff;
                  grp.item[1].last = 1'b1;
                  pend_in          = PEND_NONE;
               end else begin
                  second_in = in_byte_ff;
                  pend_in   = PEND_TWO;
               end
            end
            PEND_TWO: begin
               pend_in = PEND_NONE;
               if (in_range) begin
                  grp.cnt          = 2'd1;
                  grp.item[0].data = half[7:0];
                  grp.item[0].last = in_last_ff;
               end else begin
                  grp.cnt          = 2'd3;
                  grp.item[0].data = lead_ff;
                  grp.item[1].data = second_ff;
                  grp.item[2].data = in_byte_ff;
                  grp.item[2].last = in_last_ff;
               end
            end
            default: begin
               if (in_byte_ff[7:4] == LEAD_NIBBLE && !in_last_ff) begin
                  lead_in = in_byte_ff;
                  pend_in = PEND_LEAD;
               end else begin
                  grp.cnt          = 2'd1;
                  grp.item[0].data = in_byte_ff;
                  grp.item[0].last = in_last_ff;
                  pend_in          = PEND_NONE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_ff     <= PEND_NONE;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      lead_ff   <= lead_in;
      second_ff <= second_in;
   end

`ifndef SYNTHESIS
   // a transaction that releases nothing must leave a group open
   assert property (@(posedge clock) disable iff (reset)
      fire && grp.cnt == 2'd0 |=> pend_ff != PEND_NONE)
      else $error("byte swallowed without opening a group");

   // a group can only reach two held bytes from a held lead
   assert property (@(posedge clock) disable iff (reset)
      pend_ff == PEND_TWO && $past(pend_ff) != PEND_TWO |-> $past(pend_ff) == PEND_LEAD)
      else $error("second byte held without a lead");
`endif

endmodule

>>> hw/rtl/fw2hw_outq.sv
// ----------------------------------------------------------------------------
// fw2hw_outq
// Shifting result queue: takes up to three bytes per cycle, sends one while rsp_tready is high.
// ----------------------------------------------------------------------------
module fw2hw_outq
   import fw2hw_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  grp_type    grp,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   localparam int CW = $clog2(Depth + 1);

   item_type [Depth-1:0] q_ff, q_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        base;
   logic [CW-1:0]        push_n;
   logic [CW-1:0]        off;
   logic                 pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_tdata  = q_ff[0].data;
   assign rsp_tlast  = q_ff[0].last;
   // room for a full three byte group regardless of the output side
   assign room       = cnt_ff <= CW'(Depth - MAX_BYTES);
   assign push_n     = push ? CW'(grp.cnt) : '0;
   assign base       = cnt_ff - CW'(pop);
   assign cnt_in     = base + push_n;

   always_comb begin
      q_in = q_ff;
      off  = '0;
      if (pop) begin
         for (int i = 0; i < Depth - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < Depth; i++) begin
         off = CW'(i) - base;
         if (CW'(i) >= base && off < push_n) begin
            q_in[i] = grp.item[off[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(Depth))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push && grp.cnt != 2'd0 |-> cnt_ff <= CW'(Depth - MAX_BYTES))
      else $error("bytes pushed without room");
`endif

endmodule

>>> hw/rtl/fullwidth_to_halfwidth_converter.sv
// ----------------------------------------------------------------------------
// fullwidth_to_halfwidth_converter
// Maps UTF-8 fullwidth forms U+FF01..U+FF5E to ASCII, passes all else through.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, and the group it
//   completes is then written into the result queue, whose head drives rsp.
// Throughput: one byte per cycle in and out; input stalls while the result
//   queue holds more than Depth - 3 bytes, output while rsp_tready is low.
// Reset: synchronous, clears the input valid bit, group state and queue count.
module fullwidth_to_halfwidth_converter
   import fw2hw_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   logic    room;
   logic    fire;
   grp_type grp;

   fw2hw_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .room       (room),
      .fire       (fire),
      .grp        (grp)
   );

   fw2hw_outq #(
      .Depth (QueueDepth)
   ) u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .grp        (grp),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/sv/fullwidth_to_halfwidth_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fullwidth_to_halfwidth_converter_tb
// Self-checking bench for the UTF-8 fullwidth to halfwidth converter. Bytes
// go in as texts framed by req_tlast. A short table of directed bytes runs
// first, then about 355 bytes of random texts of ASCII, fullwidth forms and
// their neighbours, other three byte sequences and noise; some are cut short.
// A byte-level model predicts the output bytes but for typed directed rows.
// Random gaps on req and stalls on rsp move the timing around.
// ----------------------------------------------------------------------------
module fullwidth_to_halfwidth_converter_tb
   import fw2hw_pkg::*;
;

   localparam int RANDOM_ITEMS = 355;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   // one row of the directed table, an expectation is typed in when typed is set
   typedef struct packed {
      logic [7:0] din;
      logic       lin;
      logic       typed;
      logic [7:0] dout;
      logic       lout;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;

   // converter model state
   pend_type   pend_state = PEND_NONE;
   logic [7:0] held_lead;
   logic [7:0] held_second;

   item_type   converted_q[$];
   int         error_cnt = 0;
   int         bytes_sent = 0;
   int         cycle_cnt = 0;
   int         stall_left = 0;
   bit         calm = 1'b0;

   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
      '{8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1},
      // lead byte with no room for a group
      '{8'hE0, 1'b1, 1'b1, 8'hE0, 1'b1},
      // lowest fullwidth form
      '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hBC, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h81, 1'b0, 1'b1, 8'h21, 1'b0},
      // highest fullwidth form
      '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hBD, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h9E, 1'b0, 1'b1, 8'h7E, 1'b0},
      // just below and just above the range
      '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hBC, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hBD, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h9F, 1'b1, 1'b0, 8'h00, 1'b0},
      // text ends one byte after a lead
      '{8'hEE, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h41, 1'b1, 1'b0, 8'h00, 1'b0},
      // bad continuation bits still decode
      '{8'hEF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h01, 1'b1, 1'b1, 8'h21, 1'b1},
      '{8'hD0, 1'b0, 1'b1, 8'hD0, 1'b0},
      '{8'hF0, 1'b1, 1'b1, 8'hF0, 1'b1},
      '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},
      '{8'h0A, 1'b1, 1'b1, 8'h0A, 1'b1}
   };

   fullwidth_to_halfwidth_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // bytes released by one accepted input byte, updates the model state
   function automatic grp_type convert_byte(input logic [7:0] b, input logic l);
      grp_type     g;
      logic [15:0] cp;
      logic [15:0] ascii;
      g = '0;
      case (pend_state)
         PEND_LEAD: begin
            if (l) begin
               g.cnt     = 2'd2;
               g.item[0] = item_type'{held_lead, 1'b0};
               g.item[1] = item_type'{b, 1'b1};
               pend_state = PEND_NONE;
            end else begin
               held_second = b;
               pend_state  = PEND_TWO;
            end
         end
         PEND_TWO: begin
            cp = {held_lead[3:0], held_second[5:0], b[5:0]};
            pend_state = PEND_NONE;
            if (cp >= FW_LOW && cp <= FW_HIGH) begin
               ascii     = cp - FW_OFFSET;
               g.cnt     = 2'd1;
               g.item[0] = item_type'{ascii[7:0], l};
            end else begin
               g.cnt     = 2'd3;
               g.item[0] = item_type'{held_lead, 1'b0};
               g.item[1] = item_type'{held_second, 1'b0};
               g.item[2] = item_type'{b, l};
            end
         end
         default: begin
            pend_state = PEND_NONE;
            if (b[7:4] == LEAD_NIBBLE && !l) begin
               held_lead  = b;
               pend_state = PEND_LEAD;
            end else begin
               g.cnt     = 2'd1;
               g.item[0] = item_type'{b, l};
            end
         end
      endcase
      return g;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_cnt++;
   endtask

   // one req transaction, then its expected bytes are queued
   task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                            input logic [7:0] dout, input logic lout);
      int      gap;
      grp_type g;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      g = convert_byte(b, l);
      if (typed) begin
         converted_q.insert(converted_q.size(), item_type'{dout, lout});
      end else begin
         for (int k = 0; k < g.cnt; k++) converted_q.insert(converted_q.size(), g.item[k]);
      end
   endtask

   // random text of ASCII, fullwidth and other three byte sequences and noise, sometimes cut short
   task automatic send_text();
      logic [7:0]  txt[$];
      logic [15:0] cp;
      logic [7:0]  c1;
      logic [7:0]  c2;
      int          n_tok;
      int          kind;
      int          keep;
      calm  = ($urandom_range(0, 3) == 0);
      n_tok = $urandom_range(1, 10);
      for (int t = 0; t < n_tok; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            txt.insert(txt.size(), 8'($urandom_range(0, 127)));
         end else if (kind < 70) begin
            case ($urandom_range(0, 9))
               0:       cp = 16'hFF00;
               1:       cp = FW_LOW;
               2:       cp = FW_HIGH;
               3:       cp = 16'hFF5F;
               default: cp = 16'($urandom_range(FW_LOW, FW_HIGH));
            endcase
            c1 = {2'b10, cp[11:6]};
            c2 = {2'b10, cp[5:0]};
            // continuation tag bits are ignored by the block
            if ($urandom_range(0, 9) == 0) c1[7:6] = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) c2[7:6] = 2'($urandom_range(0, 3));
            txt.insert(txt.size(), {LEAD_NIBBLE, cp[15:12]});
            txt.insert(txt.size(), c1);
            txt.insert(txt.size(), c2);
         end else if (kind < 85) begin
            txt.insert(txt.size(), {LEAD_NIBBLE, 4'($urandom_range(0, 15))});
            txt.insert(txt.size(), {2'b10, 6'($urandom_range(0, 63))});
            txt.insert(txt.size(), {2'b10, 6'($urandom_range(0, 63))});
         end else begin
            txt.insert(txt.size(), 8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, txt.size());
         while (txt.size() > keep) void'(txt.pop_back());
      end
      for (int i = 0; i < txt.size(); i++)
         send_byte(txt[i], i == txt.size() - 1, 1'b0, 8'h00, 1'b0);
   endtask

   // rsp side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (converted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = converted_q.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("out_last %0b, want %0b on byte %02h",
                                         rsp_tlast, want.last, want.data));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_byte(directed_rows[i].din, directed_rows[i].lin, directed_rows[i].typed,
                   directed_rows[i].dout, directed_rows[i].lout);
      while (bytes_sent < $size(directed_rows) + RANDOM_ITEMS) send_text();
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (converted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/fw2hw_pkg.sv
hw/rtl/fw2hw_decode.sv
hw/rtl/fw2hw_outq.sv
hw/rtl/fullwidth_to_halfwidth_converter.sv
tb/sv/fullwidth_to_halfwidth_converter_tb.sv
